>>> src/apss_pkg.sv
// Shared types and constants for the adaptive policy sorted search block.
// Used by apss_mem and adaptive_policy_sorted_search. No dependencies.
package apss_pkg;

    // default geometry
    localparam int APSS_DEPTH       = 1024;
    localparam int APSS_VALUE_WIDTH = 32;

    // field widths of the stream words
    localparam int SIZE_W = 11;
    localparam int THR_W  = 17;
    localparam int EST_W  = 17;
    localparam int IDX_W  = 10;
    localparam int TGT_W  = 32;
    localparam int ITER_W = 11;
    localparam int CMP_W  = 12;

    // configuration register reset values
    localparam logic [SIZE_W-1:0] SIZE_RST = 11'd1024;
    localparam logic [THR_W-1:0]  HEAD_RST = 17'd22938;
    localparam logic [THR_W-1:0]  TAIL_RST = 17'd42598;

    // Q1.16 constants
    localparam logic [EST_W-1:0] EST_ZERO = 17'd0;
    localparam logic [EST_W-1:0] EST_HALF = 17'd32768;
    localparam logic [EST_W-1:0] EST_ONE  = 17'd65536;
    localparam int               EST_FRAC = 16;

    // configuration register indexes
    localparam logic [1:0] CFG_ARRAY_SIZE = 2'd0;
    localparam logic [1:0] CFG_HEAD_THR   = 2'd1;
    localparam logic [1:0] CFG_TAIL_THR   = 2'd2;

    // command codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        POL_BINARY = 2'd0,
        POL_TAIL   = 2'd1,
        POL_HEAD   = 2'd2
    } t_policy;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD0,
        S_RD1,
        S_DNUM,
        S_DDEN,
        S_MAG,
        S_ECHK,
        S_EDIV,
        S_POL,
        S_LOOP,
        S_SQRT,
        S_TDIV,
        S_JUMP,
        S_PRB,
        S_CMP,
        S_OUT
    } t_state;

endpackage

>>> src/apss_mem.sv
// Single-port-write, single-port-read array of signed words, registered read.
// Depends on apss_pkg for default geometry.
module apss_mem #(
    parameter int DEPTH       = apss_pkg::APSS_DEPTH,
    parameter int VALUE_WIDTH = apss_pkg::APSS_VALUE_WIDTH,
    localparam int AW         = $clog2(DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic signed [VALUE_WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]                 i_raddr,
    output logic signed [VALUE_WIDTH-1:0] o_rdata
);
    import apss_pkg::*;

    logic signed [VALUE_WIDTH-1:0] r_mem [DEPTH];
    logic signed [VALUE_WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/adaptive_policy_sorted_search.sv
// Top level of the adaptive policy sorted search block.
// Depends on apss_pkg and apss_mem.
//
// Usage:
//   Input words arrive on s_axis. tuser selects the command: a load word
//   writes load_value at load_index and gives no result; a search word
//   looks for target in entries 0..array_size-1 (array_size clamped to
//   1..DEPTH) and gives one result word on m_axis.
//   A search first reads the first and last entries and forms a Q1.16
//   position estimate, by restoring division when the estimate is a proper
//   fraction. The estimate selects the head, tail or binary probe policy.
//   Each head probe takes a bit-pair square root of the remaining count and
//   each tail probe a restoring division of rem^2 by size. The difference,
//   compare, division and square-root steps share one subtract/compare
//   unit, and all reads share one memory read port. s_axis_tready is high
//   only while idle. The result is held on m_axis until taken; no new word
//   is accepted while it waits. Reset returns to idle, loads the
//   configuration reset values and leaves the array contents undefined.
//   Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data; the
//   user must write it only while idle, as the block does not enforce this.
module adaptive_policy_sorted_search #(
    parameter int DEPTH       = apss_pkg::APSS_DEPTH,
    parameter int VALUE_WIDTH = apss_pkg::APSS_VALUE_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // load_index[9:0], load_value[41:10], target[73:42]
    input  logic        s_axis_tuser,  // cmd
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata   // found[0], position[10:1], iterations[21:11],
                                       // comparisons[33:22], policy[35:34], estimate[52:36]
);
    import apss_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int IW   = AW + 1;
    localparam int DW   = 2 * IW;
    localparam int SQW  = IW + (IW % 2);
    localparam int QW   = (DW > EST_FRAC) ? DW : EST_FRAC;
    localparam int CNTW = $clog2(QW + 1);
    localparam int CW   = (VALUE_WIDTH > TGT_W) ? VALUE_WIDTH : TGT_W;
    localparam int SW   = CW + 2;

    // input word fields
    logic                     in_cmd;
    logic [IDX_W-1:0]         in_index;
    logic signed [TGT_W-1:0]  in_value;
    logic signed [TGT_W-1:0]  in_target;
    logic                     in_acc;

    assign in_cmd    = s_axis_tuser;
    assign in_index  = s_axis_tdata[9:0];
    assign in_value  = s_axis_tdata[41:10];
    assign in_target = s_axis_tdata[73:42];
    assign in_acc    = s_axis_tvalid && s_axis_tready;

    // control registers
    t_state              r_state, n_state;
    logic [SIZE_W-1:0]   r_size;
    logic [THR_W-1:0]    r_head;
    logic [THR_W-1:0]    r_tail;

    // datapath registers
    logic signed [TGT_W-1:0]       r_tgt, n_tgt;
    logic [IW-1:0]                 r_n, n_n;
    logic signed [VALUE_WIDTH-1:0] r_first, n_first;
    logic signed [VALUE_WIDTH-1:0] r_last, n_last;
    logic signed [SW-1:0]          r_num_d, n_num_d;
    logic signed [SW-1:0]          r_den_d, n_den_d;
    logic signed [SW-1:0]          r_num, n_num;
    logic signed [SW-1:0]          r_den, n_den;
    logic                          r_nneg, n_nneg;
    logic                          r_dneg, n_dneg;
    logic signed [SW-1:0]          r_acc, n_acc;
    logic [QW-1:0]                 r_q, n_q;
    logic [DW-1:0]                 r_dvd, n_dvd;
    logic [CNTW-1:0]               r_cnt, n_cnt;
    logic [EST_W-1:0]              r_est, n_est;
    t_policy                       r_pol, n_pol;
    logic [IW-1:0]                 r_low, n_low;
    logic [IW-1:0]                 r_hi1, n_hi1;
    logic [IW-1:0]                 r_rem, n_rem;
    logic [IW-1:0]                 r_probe, n_probe;
    logic [ITER_W-1:0]             r_iters, n_iters;
    logic [CMP_W-1:0]              r_comps, n_comps;
    logic                          r_found, n_found;
    logic [IW-1:0]                 r_pos, n_pos;

    // memory
    logic                          mem_we;
    logic [AW-1:0]                 mem_raddr;
    logic signed [VALUE_WIDTH-1:0] mem_rdata;

    assign mem_we = in_acc && (in_cmd == CMD_LOAD) && (32'(in_index) < 32'(DEPTH));

    apss_mem #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (AW'(in_index)),
        .i_wdata (VALUE_WIDTH'(in_value)),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // shared subtract/compare unit
    logic signed [SW-1:0] u_a, u_b, u_d;
    logic                 u_ge;
    assign u_d  = u_a - u_b;
    assign u_ge = ~u_d[SW-1];

    // extended operands
    logic signed [SW-1:0] tgt_x, rd_x;
    assign tgt_x = SW'(r_tgt);
    assign rd_x  = SW'(mem_rdata);

    // effective size from the register
    logic [IW-1:0] n_eff;
    always_comb begin
        if (r_size == '0) begin
            n_eff = IW'(1);
        end else if (32'(r_size) > 32'(DEPTH)) begin
            n_eff = IW'(DEPTH);
        end else begin
            n_eff = IW'(r_size);
        end
    end

    // read address and unit operands
    always_comb begin
        case (r_state)
            S_RD1:   mem_raddr = AW'(r_n - 1'b1);
            S_PRB:   mem_raddr = AW'(r_probe);
            default: mem_raddr = '0;
        endcase
        case (r_state)
            S_DNUM: begin
                u_a = tgt_x;
                u_b = SW'(r_first);
            end
            S_DDEN: begin
                u_a = SW'(r_last);
                u_b = SW'(r_first);
            end
            S_ECHK: begin
                u_a = r_num;
                u_b = r_den;
            end
            S_EDIV: begin
                u_a = {r_acc[SW-2:0], 1'b0};
                u_b = r_den;
            end
            S_TDIV: begin
                u_a = {r_acc[SW-2:0], r_dvd[DW-1]};
                u_b = SW'(r_n);
            end
            S_SQRT: begin
                u_a = {r_acc[SW-3:0], r_dvd[DW-1 -: 2]};
                u_b = SW'({r_q, 2'b01});
            end
            S_CMP: begin
                u_a = rd_x;
                u_b = tgt_x;
            end
            default: begin
                u_a = '0;
                u_b = '0;
            end
        endcase
    end

    // sequencer: next state and datapath
    logic [QW-1:0] jmp;
    always_comb begin
        n_state = r_state;
        n_tgt   = r_tgt;
        n_n     = r_n;
        n_first = r_first;
        n_last  = r_last;
        n_num_d = r_num_d;
        n_den_d = r_den_d;
        n_num   = r_num;
        n_den   = r_den;
        n_nneg  = r_nneg;
        n_dneg  = r_dneg;
        n_acc   = r_acc;
        n_q     = r_q;
        n_dvd   = r_dvd;
        n_cnt   = r_cnt;
        n_est   = r_est;
        n_pol   = r_pol;
        n_low   = r_low;
        n_hi1   = r_hi1;
        n_rem   = r_rem;
        n_probe = r_probe;
        n_iters = r_iters;
        n_comps = r_comps;
        n_found = r_found;
        n_pos   = r_pos;
        jmp     = r_q;

        case (r_state)
            S_IDLE: begin
                if (in_acc && (in_cmd == CMD_SEARCH)) begin
                    n_tgt   = in_target;
                    n_n     = n_eff;
                    n_iters = '0;
                    n_comps = '0;
                    n_found = 1'b0;
                    n_pos   = '0;
                    n_state = S_RD0;
                end
            end
            S_RD0: n_state = S_RD1;
            S_RD1: begin
                n_first = mem_rdata;
                n_state = S_DNUM;
            end
            S_DNUM: begin
                n_last  = mem_rdata;
                n_num_d = u_d;
                n_state = S_DDEN;
            end
            S_DDEN: begin
                n_den_d = u_d;
                n_state = S_MAG;
            end
            // magnitudes and signs of both differences
            S_MAG: begin
                n_nneg  = r_num_d[SW-1];
                n_dneg  = r_den_d[SW-1];
                n_num   = r_num_d[SW-1] ? -r_num_d : r_num_d;
                n_den   = r_den_d[SW-1] ? -r_den_d : r_den_d;
                n_state = S_ECHK;
            end
            // special estimates, else start the fraction division
            S_ECHK: begin
                n_state = S_POL;
                if (r_den == '0) begin
                    n_est = EST_HALF;
                end else if ((r_num == '0) || (r_nneg != r_dneg)) begin
                    n_est = EST_ZERO;
                end else if (u_ge) begin
                    n_est = EST_ONE;
                end else begin
                    n_acc   = r_num;
                    n_q     = '0;
                    n_cnt   = CNTW'(EST_FRAC);
                    n_state = S_EDIV;
                end
            end
            S_EDIV: begin
                n_acc = u_ge ? u_d : u_a;
                n_q   = {r_q[QW-2:0], u_ge};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    n_est   = {1'b0, n_q[EST_FRAC-1:0]};
                    n_state = S_POL;
                end
            end
            S_POL: begin
                if (r_est <= r_head) begin
                    n_pol = POL_HEAD;
                end else if (r_est >= r_tail) begin
                    n_pol = POL_TAIL;
                end else begin
                    n_pol = POL_BINARY;
                end
                n_low   = '0;
                n_hi1   = r_n;
                n_state = S_LOOP;
            end
            // one probe per pass
            S_LOOP: begin
                if (r_low >= r_hi1) begin
                    n_state = S_OUT;
                end else begin
                    n_iters = r_iters + 1'b1;
                    n_rem   = r_hi1 - r_low;
                    n_acc   = '0;
                    n_q     = '0;
                    case (r_pol)
                        POL_HEAD: begin
                            n_dvd   = DW'(r_hi1 - r_low) << (DW - SQW);
                            n_cnt   = CNTW'(SQW / 2);
                            n_state = S_SQRT;
                        end
                        POL_TAIL: begin
                            n_dvd   = DW'(r_hi1 - r_low) * DW'(r_hi1 - r_low);
                            n_cnt   = CNTW'(DW);
                            n_state = S_TDIV;
                        end
                        default: begin
                            n_probe = r_low + ((r_hi1 - r_low - 1'b1) >> 1);
                            n_state = S_PRB;
                        end
                    endcase
                end
            end
            // bit-pair square root of the remaining count
            S_SQRT: begin
                n_acc = u_ge ? u_d : u_a;
                n_q   = {r_q[QW-2:0], u_ge};
                n_dvd = {r_dvd[DW-3:0], 2'b00};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    n_state = S_JUMP;
                end
            end
            // rem^2 / size, one quotient bit a cycle
            S_TDIV: begin
                n_acc = u_ge ? u_d : u_a;
                n_q   = {r_q[QW-2:0], u_ge};
                n_dvd = {r_dvd[DW-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    n_state = S_JUMP;
                end
            end
            // clamp the jump to [1, rem]
            S_JUMP: begin
                if (r_q == '0) begin
                    jmp = QW'(1);
                end else if (r_q > QW'(r_rem)) begin
                    jmp = QW'(r_rem);
                end else begin
                    jmp = r_q;
                end
                n_probe = r_low + IW'(jmp) - 1'b1;
                if (n_probe >= r_hi1) begin
                    n_probe = r_hi1 - 1'b1;
                end
                n_state = S_PRB;
            end
            S_PRB: n_state = S_CMP;
            // equality then ordering on the probed entry
            S_CMP: begin
                if (rd_x == tgt_x) begin
                    n_comps = r_comps + 1'b1;
                    n_found = 1'b1;
                    n_pos   = r_probe;
                    n_state = S_OUT;
                end else begin
                    n_comps = r_comps + 2'd2;
                    if (!u_ge) begin
                        n_low = r_probe + 1'b1;
                    end else begin
                        n_hi1 = r_probe;
                    end
                    n_state = S_LOOP;
                end
            end
            S_OUT: begin
                if (m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_size  <= SIZE_RST;
            r_head  <= HEAD_RST;
            r_tail  <= TAIL_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ARRAY_SIZE: r_size <= i_cfg_data[SIZE_W-1:0];
                    CFG_HEAD_THR:   r_head <= i_cfg_data;
                    CFG_TAIL_THR:   r_tail <= i_cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_tgt   <= n_tgt;
        r_n     <= n_n;
        r_first <= n_first;
        r_last  <= n_last;
        r_num_d <= n_num_d;
        r_den_d <= n_den_d;
        r_num   <= n_num;
        r_den   <= n_den;
        r_nneg  <= n_nneg;
        r_dneg  <= n_dneg;
        r_acc   <= n_acc;
        r_q     <= n_q;
        r_dvd   <= n_dvd;
        r_cnt   <= n_cnt;
        r_est   <= n_est;
        r_pol   <= n_pol;
        r_low   <= n_low;
        r_hi1   <= n_hi1;
        r_rem   <= n_rem;
        r_probe <= n_probe;
        r_iters <= n_iters;
        r_comps <= n_comps;
        r_found <= n_found;
        r_pos   <= n_pos;
    end

    // ports
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {3'b000, r_est, r_pol, r_comps, r_iters, IDX_W'(r_pos), r_found};

    // checks
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while a result is pending");

    a_probe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> ((r_probe >= r_low) && (r_probe < r_hi1)))
        else $error("probe outside the live window");

    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready) |=> s_axis_tready)
        else $error("no return to idle after result taken");

    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (32'(r_iters) <= 32'(r_n)))
        else $error("more probes than entries");

endmodule
